[rtl/prime_implicant_tabulator_macros.svh]
// Assertion macros used by the prime implicant tabulator engine.
`ifndef PRIME_IMPLICANT_TABULATOR_MACROS_SVH
`define PRIME_IMPLICANT_TABULATOR_MACROS_SVH

// Checks a property on every clock edge outside of reset.
`define PIT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequent sequence outside of reset.
`define PIT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/pit_pkg.sv]
// Shared constants, types and a helper function of the prime implicant tabulator.
`default_nettype none
package pit_pkg;
  localparam int MAX_VARS_DEF     = 6;
  localparam int COLUMN_DEPTH_DEF = 256;
  localparam int NV_W             = 3;
  localparam int CNT_W            = 7;
  localparam int OUT_LIMIT        = 64;
  localparam int OUT_AW           = $clog2(OUT_LIMIT);
  localparam int NOUT_W           = $clog2(OUT_LIMIT + 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = 7'd127;
  localparam logic [NV_W-1:0]  NV_RESET = 3'd4;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [NV_W-1:0]  nv;
  } job_ctl_t;

  function automatic logic [3:0] ones8(input logic [7:0] x);
    logic [3:0] c;
    c = 4'd0;
    for (int b = 0; b < 8; b++) begin
      c = c + {3'd0, x[b]};
    end
    return c;
  endfunction
endpackage
`default_nettype wire

[rtl/pit_front.sv]
// Front end: configuration register, minterm set and item count, hands runs to the queue.
`default_nettype none
module pit_front import pit_pkg::*; #(
  parameter int MAX_VARS = MAX_VARS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [NV_W-1:0]          cfg_var_count,
  input  wire logic                     start,
  input  wire logic [MAX_VARS-1:0]      in_minterm,
  input  wire logic                     in_last,
  input  wire logic                     q_full,
  output logic                          busy,
  output logic                          q_push,
  output logic [(2**MAX_VARS)-1:0]      q_map,
  output job_ctl_t                      q_ctl
);
  localparam int MAPW = 2**MAX_VARS;

  logic [NV_W-1:0]     nv_r;
  logic [MAPW-1:0]     map_r, map_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [NV_W-1:0]     nv_eff;
  logic [MAX_VARS-1:0] mask;
  logic [MAX_VARS-1:0] m;
  logic                accept;

  always_comb begin
    if (nv_r == '0) begin
      nv_eff = NV_W'(1);
    end else if (int'(nv_r) > MAX_VARS) begin
      nv_eff = NV_W'(MAX_VARS);
    end else begin
      nv_eff = nv_r;
    end
  end

  assign mask      = ~({MAX_VARS{1'b1}} << nv_eff);
  assign m         = in_minterm & mask;
  assign accept    = start & ~q_full;
  assign busy      = q_full;
  assign map_nxt   = map_r | (MAPW'(1) << m);
  assign count_nxt = (count_r < CNT_MAX) ? count_r + CNT_W'(1) : count_r;
  assign q_push    = accept & in_last;
  assign q_map     = map_nxt;
  assign q_ctl     = '{count: count_nxt, nv: nv_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r    <= NV_RESET;
      map_r   <= '0;
      count_r <= '0;
    end else begin
      if (cfg_we) begin
        nv_r <= cfg_var_count;
      end
      if (accept) begin
        // The last item closes the run: its set goes to the queue and the front starts over.
        if (in_last) begin
          map_r   <= '0;
          count_r <= '0;
        end else begin
          map_r   <= map_nxt;
          count_r <= count_nxt;
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/pit_queue.sv]
// Two-entry queue of loaded runs between the front end and the tabulation engine.
`default_nettype none
module pit_queue import pit_pkg::*; #(
  parameter int MAX_VARS = MAX_VARS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic [(2**MAX_VARS)-1:0]    push_map,
  input  wire job_ctl_t                    push_ctl,
  input  wire logic                        pop,
  output logic                             full,
  output logic                             empty,
  output logic [(2**MAX_VARS)-1:0]         head_map,
  output job_ctl_t                         head_ctl
);
  localparam int MAPW = 2**MAX_VARS;

  logic [MAPW-1:0] map_q [2];
  job_ctl_t        ctl_q [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign head_map = map_q[rp_r];
  assign head_ctl = ctl_q[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      map_q[wp_r] <= push_map;
      ctl_q[wp_r] <= push_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[rtl/pit_engine.sv]
// Tabulation engine: builds columns, pairs terms, collects primes and plays them out.
`default_nettype none
module pit_engine import pit_pkg::*; #(
  parameter int MAX_VARS     = MAX_VARS_DEF,
  parameter int COLUMN_DEPTH = COLUMN_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_empty,
  input  wire logic [(2**MAX_VARS)-1:0]  q_map,
  input  wire job_ctl_t                  q_ctl,
  output logic                           q_pop,
  output logic                           out_strobe,
  output logic [MAX_VARS-1:0]            out_term_value,
  output logic [MAX_VARS-1:0]            out_dash_mask,
  output logic                           out_end_of_list,
  output logic                           out_truncated
);
  `include "prime_implicant_tabulator_macros.svh"

  localparam int MAPW = 2**MAX_VARS;
  localparam int EW   = 2 * MAX_VARS;
  localparam int AW   = $clog2(COLUMN_DEPTH);
  localparam int CW   = $clog2(COLUMN_DEPTH + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_BUILD  = 4'd1;
  localparam logic [3:0] S_ILOAD  = 4'd2;
  localparam logic [3:0] S_ILATCH = 4'd3;
  localparam logic [3:0] S_JREAD  = 4'd4;
  localparam logic [3:0] S_JCMP   = 4'd5;
  localparam logic [3:0] S_SRCH   = 4'd6;
  localparam logic [3:0] S_SCMP   = 4'd7;
  localparam logic [3:0] S_EREAD  = 4'd8;
  localparam logic [3:0] S_ECHK   = 4'd9;
  localparam logic [3:0] S_OREAD  = 4'd10;
  localparam logic [3:0] S_ODATA  = 4'd11;

  // Column entries are {dash mask, literal values}.
  logic [EW-1:0] col_a [COLUMN_DEPTH];
  logic [EW-1:0] col_b [COLUMN_DEPTH];
  logic          flg_a [COLUMN_DEPTH];
  logic          flg_b [COLUMN_DEPTH];
  logic [EW-1:0] prime_buf [OUT_LIMIT];

  logic [3:0]          state_r, state_nxt;
  logic                sel_r, sel_nxt;
  logic [MAPW-1:0]     map_r, map_nxt;
  logic [NV_W-1:0]     nv_r, nv_nxt;
  logic [CNT_W-1:0]    cap_r, cap_nxt;
  logic [MAX_VARS-1:0] v_r, v_nxt;
  logic [NV_W-1:0]     ones_r, ones_nxt;
  logic [CW-1:0]       cur_n_r, cur_n_nxt, nxt_n_r, nxt_n_nxt;
  logic [CW-1:0]       i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [EW-1:0]       ti_r, ti_nxt, t_r, t_nxt;
  logic                fi_r, fi_nxt;
  logic [NOUT_W-1:0]   nout_r, nout_nxt, o_r, o_nxt;
  logic                trunc_r, trunc_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  logic [EW-1:0]       out_data_r, out_data_nxt;
  logic                out_eol_r, out_eol_nxt;
  logic                out_trunc_r, out_trunc_nxt;

  // Role-based memory controls, mapped onto the two banks by sel_r.
  logic [AW-1:0] cur_raddr, nxt_raddr;
  logic          cur_we, nxt_we;
  logic [AW-1:0] cur_waddr, nxt_waddr;
  logic [EW-1:0] cur_wdata, nxt_wdata;
  logic          curf_we, nxtf_we;
  logic [AW-1:0] curf_waddr, nxtf_waddr;
  logic          curf_wdata;
  logic          buf_we;
  logic [OUT_AW-1:0] buf_waddr, buf_raddr;

  logic [AW-1:0] a_raddr, b_raddr, a_waddr, b_waddr, af_waddr, bf_waddr;
  logic          a_we, b_we, af_we, bf_we, af_wdata, bf_wdata;
  logic [EW-1:0] a_wdata, b_wdata;
  logic [EW-1:0] a_q_r, b_q_r, buf_q_r;
  logic          af_q_r, bf_q_r;
  logic [EW-1:0] cur_q, nxt_q;
  logic          curf_q;

  logic [MAX_VARS-1:0] mask;
  logic [MAX_VARS-1:0] vi, di, vj, dj, diff;
  logic                pair_hit;
  logic [EW-1:0]       t_new;

  assign mask = ~({MAX_VARS{1'b1}} << nv_r);

  assign vi   = ti_r[MAX_VARS-1:0];
  assign di   = ti_r[EW-1:MAX_VARS];
  assign vj   = cur_q[MAX_VARS-1:0];
  assign dj   = cur_q[EW-1:MAX_VARS];
  assign diff = (di ^ dj) | (vi ^ vj);
  assign pair_hit = (ones8(8'(vj)) == ones8(8'(vi)) + 4'd1) && $onehot(diff);
  assign t_new    = {di | diff, vi & ~diff};

  assign cur_q  = sel_r ? b_q_r : a_q_r;
  assign nxt_q  = sel_r ? a_q_r : b_q_r;
  assign curf_q = sel_r ? bf_q_r : af_q_r;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    map_nxt   = map_r;
    nv_nxt    = nv_r;
    cap_nxt   = cap_r;
    v_nxt     = v_r;
    ones_nxt  = ones_r;
    cur_n_nxt = cur_n_r;
    nxt_n_nxt = nxt_n_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    ti_nxt    = ti_r;
    t_nxt     = t_r;
    fi_nxt    = fi_r;
    nout_nxt  = nout_r;
    o_nxt     = o_r;
    trunc_nxt = trunc_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    out_eol_nxt    = out_eol_r;
    out_trunc_nxt  = out_trunc_r;
    q_pop      = 1'b0;
    cur_raddr  = i_r[AW-1:0];
    nxt_raddr  = k_r[AW-1:0];
    cur_we     = 1'b0;
    cur_waddr  = cur_n_r[AW-1:0];
    cur_wdata  = {{MAX_VARS{1'b0}}, v_r};
    nxt_we     = 1'b0;
    nxt_waddr  = nxt_n_r[AW-1:0];
    nxt_wdata  = t_r;
    curf_we    = 1'b0;
    curf_waddr = i_r[AW-1:0];
    curf_wdata = 1'b0;
    nxtf_we    = 1'b0;
    nxtf_waddr = nxt_n_r[AW-1:0];
    buf_we     = 1'b0;
    buf_waddr  = nout_r[OUT_AW-1:0];
    buf_raddr  = o_r[OUT_AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          map_nxt   = q_map;
          nv_nxt    = q_ctl.nv;
          cap_nxt   = (q_ctl.count < CNT_W'(OUT_LIMIT)) ? q_ctl.count : CNT_W'(OUT_LIMIT);
          v_nxt     = '0;
          ones_nxt  = '0;
          cur_n_nxt = '0;
          nout_nxt  = '0;
          trunc_nxt = 1'b0;
          sel_nxt   = 1'b0;
          state_nxt = S_BUILD;
        end
      end
      S_BUILD: begin
        // Column one: scan every value once per ones count, so the list comes out sorted.
        if (map_r[v_r] && (ones8(8'(v_r)) == 4'(ones_r)) &&
            (cur_n_r < CW'(COLUMN_DEPTH))) begin
          cur_we    = 1'b1;
          curf_we   = 1'b1;
          curf_waddr = cur_n_r[AW-1:0];
          cur_n_nxt = cur_n_r + CW'(1);
        end
        if (v_r == mask) begin
          v_nxt = '0;
          if (ones_r == nv_r) begin
            i_nxt     = '0;
            nxt_n_nxt = '0;
            state_nxt = S_ILOAD;
          end else begin
            ones_nxt = ones_r + NV_W'(1);
          end
        end else begin
          v_nxt = v_r + MAX_VARS'(1);
        end
      end
      S_ILOAD: begin
        if (i_r == cur_n_r) begin
          i_nxt     = '0;
          state_nxt = S_EREAD;
        end else begin
          state_nxt = S_ILATCH;
        end
      end
      S_ILATCH: begin
        ti_nxt    = cur_q;
        fi_nxt    = curf_q;
        j_nxt     = i_r + CW'(1);
        state_nxt = S_JREAD;
      end
      S_JREAD: begin
        cur_raddr = j_r[AW-1:0];
        if (j_r == cur_n_r) begin
          curf_we    = 1'b1;
          curf_wdata = fi_r;
          i_nxt      = i_r + CW'(1);
          state_nxt  = S_ILOAD;
        end else begin
          state_nxt = S_JCMP;
        end
      end
      S_JCMP: begin
        if (pair_hit) begin
          fi_nxt     = 1'b1;
          curf_we    = 1'b1;
          curf_waddr = j_r[AW-1:0];
          curf_wdata = 1'b1;
          t_nxt      = t_new;
          k_nxt      = '0;
          state_nxt  = S_SRCH;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_JREAD;
        end
      end
      S_SRCH: begin
        // Walk the next column for a copy of the new term; append it if none is found and there is room.
        if (k_r == nxt_n_r) begin
          if (nxt_n_r < CW'(COLUMN_DEPTH)) begin
            nxt_we    = 1'b1;
            nxtf_we   = 1'b1;
            nxt_n_nxt = nxt_n_r + CW'(1);
          end
          j_nxt     = j_r + CW'(1);
          state_nxt = S_JREAD;
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (nxt_q == t_r) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_JREAD;
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_SRCH;
        end
      end
      S_EREAD: begin
        if (i_r == cur_n_r) begin
          if (nxt_n_r == '0) begin
            o_nxt     = '0;
            state_nxt = (nout_r == '0) ? S_IDLE : S_OREAD;
          end else begin
            sel_nxt   = ~sel_r;
            cur_n_nxt = nxt_n_r;
            nxt_n_nxt = '0;
            i_nxt     = '0;
            state_nxt = S_ILOAD;
          end
        end else begin
          state_nxt = S_ECHK;
        end
      end
      S_ECHK: begin
        if (!curf_q) begin
          if (NOUT_W'(cap_r) > nout_r) begin
            buf_we   = 1'b1;
            nout_nxt = nout_r + NOUT_W'(1);
          end else begin
            trunc_nxt = 1'b1;
          end
        end
        i_nxt     = i_r + CW'(1);
        state_nxt = S_EREAD;
      end
      S_OREAD: begin
        state_nxt = S_ODATA;
      end
      S_ODATA: begin
        out_strobe_nxt = 1'b1;
        out_data_nxt   = buf_q_r;
        out_trunc_nxt  = trunc_r;
        out_eol_nxt    = (o_r == nout_r - NOUT_W'(1));
        o_nxt          = o_r + NOUT_W'(1);
        state_nxt      = out_eol_nxt ? S_IDLE : S_OREAD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign a_raddr  = sel_r ? nxt_raddr  : cur_raddr;
  assign b_raddr  = sel_r ? cur_raddr  : nxt_raddr;
  assign a_we     = sel_r ? nxt_we     : cur_we;
  assign b_we     = sel_r ? cur_we     : nxt_we;
  assign a_waddr  = sel_r ? nxt_waddr  : cur_waddr;
  assign b_waddr  = sel_r ? cur_waddr  : nxt_waddr;
  assign a_wdata  = sel_r ? nxt_wdata  : cur_wdata;
  assign b_wdata  = sel_r ? cur_wdata  : nxt_wdata;
  assign af_we    = sel_r ? nxtf_we    : curf_we;
  assign bf_we    = sel_r ? curf_we    : nxtf_we;
  assign af_waddr = sel_r ? nxtf_waddr : curf_waddr;
  assign bf_waddr = sel_r ? curf_waddr : nxtf_waddr;
  assign af_wdata = sel_r ? 1'b0       : curf_wdata;
  assign bf_wdata = sel_r ? curf_wdata : 1'b0;

  always_ff @(posedge clk) begin
    if (a_we) begin
      col_a[a_waddr] <= a_wdata;
    end
    a_q_r <= col_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      col_b[b_waddr] <= b_wdata;
    end
    b_q_r <= col_b[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (af_we) begin
      flg_a[af_waddr] <= af_wdata;
    end
    af_q_r <= flg_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (bf_we) begin
      flg_b[bf_waddr] <= bf_wdata;
    end
    bf_q_r <= flg_b[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      prime_buf[buf_waddr] <= cur_q;
    end
    buf_q_r <= prime_buf[buf_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sel_r        <= 1'b0;
      cur_n_r      <= '0;
      nxt_n_r      <= '0;
      nout_r       <= '0;
      cap_r        <= '0;
      trunc_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sel_r        <= sel_nxt;
      cur_n_r      <= cur_n_nxt;
      nxt_n_r      <= nxt_n_nxt;
      nout_r       <= nout_nxt;
      cap_r        <= cap_nxt;
      trunc_r      <= trunc_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    map_r       <= map_nxt;
    nv_r        <= nv_nxt;
    v_r         <= v_nxt;
    ones_r      <= ones_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    ti_r        <= ti_nxt;
    t_r         <= t_nxt;
    fi_r        <= fi_nxt;
    o_r         <= o_nxt;
    out_data_r  <= out_data_nxt;
    out_eol_r   <= out_eol_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_term_value  = out_data_r[MAX_VARS-1:0];
  assign out_dash_mask   = out_data_r[EW-1:MAX_VARS];
  assign out_end_of_list = out_eol_r;
  assign out_truncated   = out_trunc_r;

  `PIT_ASSERT(a_nout_cap, NOUT_W'(cap_r) >= nout_r, "prime count passed the output cap")
  `PIT_ASSERT(a_list_depth, (cur_n_r <= CW'(COLUMN_DEPTH)) && (nxt_n_r <= CW'(COLUMN_DEPTH)), "column count passed its depth")
  `PIT_ASSERT_IMP(a_eol_gap, out_strobe_r && out_eol_r, ##1 !out_strobe_r, "result right after end of list")
  `PIT_ASSERT_IMP(a_trunc_steady, out_strobe_r && !out_eol_r, ##2 (out_strobe_r && (out_trunc_r == $past(out_trunc_r, 2))), "truncated flag changed within a run")
endmodule
`default_nettype wire

[rtl/prime_implicant_tabulator.sv]
// Top level of the prime implicant tabulator: front end, run queue and tabulation engine.
`default_nettype none
// Minterms load one item per cycle while busy is low; the item with in_last set closes
// the run and hands the recorded set to a two-run queue, so loading of the next run goes
// on while the engine works. busy is high only while two closed runs wait. For n inputs
// the engine picks up a run and builds column one by scanning all 2^n values once per
// ones count. Each column is then compared pair by pair; each combination searches the
// next column for a copy and appends the term if none is found and there is room.
// Primes are collected column by column and each is played out on the result ports.
// Results appear one per strobe cycle and cannot be held off; out_truncated is the same
// on every result of a run and out_end_of_list marks the last.
module prime_implicant_tabulator import pit_pkg::*; #(
  parameter int MAX_VARS     = MAX_VARS_DEF,
  parameter int COLUMN_DEPTH = COLUMN_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [NV_W-1:0]      cfg_var_count,
  input  wire logic                 start,
  input  wire logic [MAX_VARS-1:0]  in_minterm,
  input  wire logic                 in_last,
  output logic                      busy,
  output logic                      out_strobe,
  output logic [MAX_VARS-1:0]       out_term_value,
  output logic [MAX_VARS-1:0]       out_dash_mask,
  output logic                      out_end_of_list,
  output logic                      out_truncated
);
  localparam int MAPW = 2**MAX_VARS;

  logic            q_push, q_pop, q_full, q_empty;
  logic [MAPW-1:0] push_map, head_map;
  job_ctl_t        push_ctl, head_ctl;

  pit_front #(.MAX_VARS(MAX_VARS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_var_count (cfg_var_count),
    .start         (start),
    .in_minterm    (in_minterm),
    .in_last       (in_last),
    .q_full        (q_full),
    .busy          (busy),
    .q_push        (q_push),
    .q_map         (push_map),
    .q_ctl         (push_ctl)
  );

  pit_queue #(.MAX_VARS(MAX_VARS)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_map (push_map),
    .push_ctl (push_ctl),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_map (head_map),
    .head_ctl (head_ctl)
  );

  pit_engine #(.MAX_VARS(MAX_VARS), .COLUMN_DEPTH(COLUMN_DEPTH)) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_map           (head_map),
    .q_ctl           (head_ctl),
    .q_pop           (q_pop),
    .out_strobe      (out_strobe),
    .out_term_value  (out_term_value),
    .out_dash_mask   (out_dash_mask),
    .out_end_of_list (out_end_of_list),
    .out_truncated   (out_truncated)
  );
endmodule
`default_nettype wire
